// ----- sv/text_cell_buffer_blitter_core_assert.svh -----
// Assertion macros for the text cell blitter core.
// Used by the top level only; no other dependencies.
`ifndef TEXT_CELL_BUFFER_BLITTER_CORE_ASSERT_SVH
`define TEXT_CELL_BUFFER_BLITTER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define TCB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define TCB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/tcb_pkg.sv -----
// Shared types, constants and glyph tables of the text cell blitter.
// No dependencies.
`timescale 1ns / 1ps

package tcb_pkg;

  // signed working width for coordinates and region edges
  localparam int SW = 13;
  typedef logic signed [SW-1:0] sval_t;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 1'd1;

  localparam logic [7:0] COLUMNS_RESET = 8'd80;
  localparam logic [6:0] ROWS_RESET    = 7'd24;

  typedef enum logic [2:0] {
    OP_PUT, OP_CP437, OP_FILL, OP_COPY, OP_VSCROLL, OP_HSCROLL, OP_READ, OP_UNUSED
  } op_t;

  // kind of work done by one region pass
  typedef enum logic [1:0] {K_NONE, K_FILL, K_BLIT, K_READ} kind_t;

  typedef struct packed {
    logic [2:0]        opcode;
    logic signed [9:0] pos_x;
    logic signed [9:0] pos_y;
    logic signed [9:0] area_w;
    logic signed [9:0] area_h;
    logic              whole_screen;
    logic signed [9:0] dest_x;
    logic signed [9:0] dest_y;
    logic signed [9:0] shift;
    logic [15:0]       char_code;
    logic [7:0]        fg_color;
    logic [7:0]        bg_color;
  } tcb_in_t;

  // controller -> datapath
  typedef struct packed {
    logic latch_cmd;
    logic prep;
    logic load;
    logic pass;
    logic fill_we;
    logic blit_rd;
    logic blit_wr;
    logic rd;
    logic clr_we;
    logic step;
    logic emit;
  } tcb_cmd_t;

  // datapath -> controller
  typedef struct packed {
    kind_t kind;
    logic  ne;
    logic  last;
    logic  clr_last;
  } tcb_sts_t;

  localparam logic [15:0] LOW_GLYPHS [32] = '{
    16'h0020, 16'h263a, 16'h263b, 16'h2665, 16'h2666, 16'h2663, 16'h2660, 16'h2022,
    16'h25d8, 16'h25cb, 16'h25d9, 16'h2642, 16'h2640, 16'h266a, 16'h266b, 16'h263c,
    16'h25ba, 16'h25c4, 16'h2195, 16'h203c, 16'h00b6, 16'h00a7, 16'h25ac, 16'h21a8,
    16'h2191, 16'h2193, 16'h2192, 16'h2190, 16'h221f, 16'h2194, 16'h25b2, 16'h25bc
  };

  localparam logic [15:0] HIGH_GLYPHS [129] = '{
    16'h2302,
    16'h00c7, 16'h00fc, 16'h00e9, 16'h00e2, 16'h00e4, 16'h00e0, 16'h00e5, 16'h00e7,
    16'h00ea, 16'h00eb, 16'h00e8, 16'h00ef, 16'h00ee, 16'h00ec, 16'h00c4, 16'h00c5,
    16'h00c9, 16'h00e6, 16'h00c6, 16'h00f4, 16'h00f6, 16'h00f2, 16'h00fb, 16'h00f9,
    16'h00ff, 16'h00d6, 16'h00dc, 16'h00a2, 16'h00a3, 16'h00a5, 16'h20a7, 16'h0192,
    16'h00e1, 16'h00ed, 16'h00f3, 16'h00fa, 16'h00f1, 16'h00d1, 16'h00aa, 16'h00ba,
    16'h00bf, 16'h2310, 16'h00ac, 16'h00bd, 16'h00bc, 16'h00a1, 16'h00ab, 16'h00bb,
    16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
    16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255d, 16'h255c, 16'h255b, 16'h2510,
    16'h2514, 16'h2534, 16'h252c, 16'h251c, 16'h2500, 16'h253c, 16'h255e, 16'h255f,
    16'h255a, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256c, 16'h2567,
    16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256b,
    16'h256a, 16'h2518, 16'h250c, 16'h2588, 16'h2584, 16'h258c, 16'h2590, 16'h2580,
    16'h03b1, 16'h00df, 16'h0393, 16'h03c0, 16'h03a3, 16'h03c3, 16'h00b5, 16'h03c4,
    16'h03a6, 16'h0398, 16'h03a9, 16'h03b4, 16'h221e, 16'h03c6, 16'h03b5, 16'h2229,
    16'h2261, 16'h00b1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00f7, 16'h2248,
    16'h00b0, 16'h2219, 16'h00b7, 16'h221a, 16'h207f, 16'h00b2, 16'h25a0, 16'h00a0
  };

  // CP437 byte to its glyph code point
  function automatic logic [15:0] cp437_glyph(input logic [7:0] code);
    logic [15:0] g;
    if (code < 8'd32) g = LOW_GLYPHS[code[4:0]];
    else if (code < 8'd127) g = {8'h00, code};
    else g = HIGH_GLYPHS[8'(code - 8'd127)];
    return g;
  endfunction

  // cell layout: bg | fg | char
  function automatic logic [31:0] pack_cell(input logic [15:0] ch, input logic [7:0] fg,
                                            input logic [7:0] bg);
    return {bg, fg, ch};
  endfunction

  function automatic sval_t sx10(input logic [9:0] v);
    return {{(SW-10){v[9]}}, v};
  endfunction

endpackage

// ----- sv/tcb_if.sv -----
// Handshake channel interfaces: command input, cell result, register write.
// Depends on tcb_pkg for the register index width.
`timescale 1ns / 1ps

interface tcb_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        opcode;
  logic signed [9:0] pos_x;
  logic signed [9:0] pos_y;
  logic signed [9:0] area_w;
  logic signed [9:0] area_h;
  logic              whole_screen;
  logic signed [9:0] dest_x;
  logic signed [9:0] dest_y;
  logic signed [9:0] shift;
  logic [15:0]       char_code;
  logic [7:0]        fg_color;
  logic [7:0]        bg_color;
  modport source (output valid, opcode, pos_x, pos_y, area_w, area_h, whole_screen,
                  dest_x, dest_y, shift, char_code, fg_color, bg_color, input ready);
  modport sink   (input valid, opcode, pos_x, pos_y, area_w, area_h, whole_screen,
                  dest_x, dest_y, shift, char_code, fg_color, bg_color, output ready);
endinterface

interface tcb_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] cell_char;
  logic [7:0]  cell_fg;
  logic [7:0]  cell_bg;
  logic        skipped;
  modport source (output valid, cell_char, cell_fg, cell_bg, skipped, input ready);
  modport sink   (input valid, cell_char, cell_fg, cell_bg, skipped, output ready);
endinterface

interface tcb_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tcb_pkg::CFG_IDX_W-1:0] reg_index;
  logic [7:0]                    wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ----- sv/text_cell_buffer_blitter_core.sv -----
// Text cell blitter top: controller plus datapath over one cell store.
// A command is latched, set up and run over its region passes, then its result beat is emitted.
// One command in flight; the next can be taken in the cycle after the result is emitted.
// After reset a clearing pass writes MAX_COLS*MAX_ROWS cells, one per cycle, before
// the first command is taken; registers reset to 80 columns and 24 rows.
`timescale 1ns / 1ps
`include "text_cell_buffer_blitter_core_assert.svh"

module text_cell_buffer_blitter_core
  import tcb_pkg::*;
#(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  tcb_in_if.sink    in_ch,
  tcb_out_if.source out_ch,
  tcb_cfg_if.sink   cfg_ch
);

  tcb_cmd_t cmd;
  tcb_sts_t sts;
  tcb_in_t  in_item;

  assign in_item = '{opcode: in_ch.opcode, pos_x: in_ch.pos_x, pos_y: in_ch.pos_y,
                     area_w: in_ch.area_w, area_h: in_ch.area_h,
                     whole_screen: in_ch.whole_screen, dest_x: in_ch.dest_x,
                     dest_y: in_ch.dest_y, shift: in_ch.shift,
                     char_code: in_ch.char_code, fg_color: in_ch.fg_color,
                     bg_color: in_ch.bg_color};

  // register writes are always taken
  assign cfg_ch.ready = 1'b1;

  tcb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcb_dpath #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_item   (in_item),
    .cfg_we    (cfg_ch.valid),
    .cfg_idx   (cfg_ch.reg_index),
    .cfg_data  (cfg_ch.wdata),
    .cell_char (out_ch.cell_char),
    .cell_fg   (out_ch.cell_fg),
    .cell_bg   (out_ch.cell_bg),
    .skipped   (out_ch.skipped)
  );

  // checks
  `TCB_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready, "two in flight")
  `TCB_ASSERT_NOW(a_clear_blocks_in, clk, rst_n, cmd.clr_we, !in_ch.ready, "taken while clearing")
  `TCB_ASSERT_NOW(a_emit_free, clk, rst_n, cmd.emit, !out_ch.valid || out_ch.ready, "beat overwritten")

endmodule

// ----- sv/tcb_ctrl.sv -----
// Controller: sequences clear pass, command setup, region passes and result.
// Depends on tcb_pkg.
`timescale 1ns / 1ps

module tcb_ctrl
  import tcb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     out_ready,
  output logic     out_valid,
  input  tcb_sts_t sts,
  output tcb_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_PREP, ST_LOAD, ST_DISP, ST_FILL,
    ST_BRD, ST_BWR, ST_RRD, ST_ADV, ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   pass_r, pass_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    pass_nxt      = pass_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.pass      = pass_r;
    in_ready      = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_cmd = 1'b1;
          pass_nxt      = 1'b0;
          state_nxt     = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = ST_DISP;
      end
      ST_DISP: begin
        case (sts.kind)
          K_FILL:  state_nxt = sts.ne ? ST_FILL : ST_ADV;
          K_BLIT:  state_nxt = sts.ne ? ST_BRD : ST_ADV;
          K_READ:  state_nxt = sts.ne ? ST_RRD : ST_ADV;
          default: state_nxt = ST_ADV;
        endcase
      end
      ST_FILL: begin
        cmd.fill_we = 1'b1;
        cmd.step    = 1'b1;
        if (sts.last) state_nxt = ST_ADV;
      end
      ST_BRD: begin
        cmd.blit_rd = 1'b1;
        state_nxt   = ST_BWR;
      end
      ST_BWR: begin
        cmd.blit_wr = 1'b1;
        cmd.step    = 1'b1;
        state_nxt   = sts.last ? ST_ADV : ST_BRD;
      end
      ST_RRD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_ADV;
      end
      ST_ADV: begin
        if (pass_r) state_nxt = ST_DONE;
        else begin
          pass_nxt  = 1'b1;
          state_nxt = ST_LOAD;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- sv/tcb_dpath.sv -----
// Datapath: config registers, command latch, region clipping, cell walker,
// cell store memory and result register. Depends on tcb_pkg.
`timescale 1ns / 1ps

module tcb_dpath
  import tcb_pkg::*;
#(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tcb_cmd_t             cmd,
  output tcb_sts_t             sts,
  input  tcb_in_t              in_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [7:0]           cfg_data,
  output logic [15:0]          cell_char,
  output logic [7:0]           cell_fg,
  output logic [7:0]           cell_bg,
  output logic                 skipped
);

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int ECW   = $clog2(MAX_COLS + 1);
  localparam int ERW   = $clog2(MAX_ROWS + 1);

  // configuration
  logic [7:0] columns_r;
  logic [6:0] rows_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r <= COLUMNS_RESET;
      rows_r    <= ROWS_RESET;
    end else if (cfg_we) begin
      if (cfg_idx == REG_COLUMNS) columns_r <= cfg_data;
      if (cfg_idx == REG_ROWS)    rows_r    <= cfg_data[6:0];
    end
  end

  // effective screen size
  logic [15:0]    cols16, rows16;
  logic [ECW-1:0] ec;
  logic [ERW-1:0] er;
  sval_t          ec_s, er_s;
  assign cols16 = 16'(columns_r);
  assign rows16 = 16'(rows_r);
  assign ec = (cols16 > 16'(MAX_COLS)) ? ECW'(MAX_COLS) : ECW'(cols16);
  assign er = (rows16 > 16'(MAX_ROWS)) ? ERW'(MAX_ROWS) : ERW'(rows16);
  assign ec_s = sval_t'(ec);
  assign er_s = sval_t'(er);

  // command latch
  op_t               op_r;
  logic signed [9:0] px_r, py_r, rw_r, rh_r, dx_r, dy_r, sh_r;
  logic [31:0]       cell_r;
  always_ff @(posedge clk) begin
    if (cmd.latch_cmd) begin
      op_r <= op_t'(in_item.opcode);
      if (in_item.whole_screen) begin
        px_r <= '0;
        py_r <= '0;
        rw_r <= 10'(ec);
        rh_r <= 10'(er);
      end else begin
        px_r <= in_item.pos_x;
        py_r <= in_item.pos_y;
        rw_r <= in_item.area_w;
        rh_r <= in_item.area_h;
      end
      dx_r <= in_item.dest_x;
      dy_r <= in_item.dest_y;
      sh_r <= in_item.shift;
      if (op_t'(in_item.opcode) == OP_CP437)
        cell_r <= pack_cell(cp437_glyph(in_item.char_code[7:0]),
                            {4'h0, in_item.fg_color[3:0]}, {4'h0, in_item.fg_color[7:4]});
      else
        cell_r <= pack_cell(in_item.char_code, in_item.fg_color, in_item.bg_color);
    end
  end

  sval_t px_s, py_s, rw_s, rh_s, dx_s, dy_s, sh_s;
  assign px_s = sx10(px_r);
  assign py_s = sx10(py_r);
  assign rw_s = sx10(rw_r);
  assign rh_s = sx10(rh_r);
  assign dx_s = sx10(dx_r);
  assign dy_s = sx10(dy_r);
  assign sh_s = sx10(sh_r);

  // scroll magnitude, clamped to the region size
  logic [9:0] mag_r;
  sval_t      mag_s, shm_s, size_s, magv_s;
  logic       sh_neg, sh_zero;
  assign sh_neg  = sh_r[9];
  assign sh_zero = (sh_r == '0);
  assign shm_s   = sh_neg ? -sh_s : sh_s;
  always_comb begin
    size_s = (op_r == OP_VSCROLL) ? rh_s : rw_s;
    if (size_s < 0) size_s = '0;
    magv_s = (shm_s > size_s) ? size_s : shm_s;
  end
  assign mag_s = sval_t'(mag_r);

  // region of the current pass
  sval_t rx, ry, rwd, rht, ox, oy;
  always_comb begin
    rx = px_s; ry = py_s; rwd = rw_s; rht = rh_s; ox = '0; oy = '0;
    if (!cmd.prep && !cmd.pass) begin
      case (op_r)
        OP_PUT, OP_CP437, OP_READ: begin
          rwd = sval_t'(1);
          rht = sval_t'(1);
        end
        OP_COPY: begin
          ox = dx_s - px_s;
          oy = dy_s - py_s;
        end
        OP_VSCROLL: begin
          rht = rh_s - mag_s;
          if (sh_neg) begin
            ry = py_s + mag_s;
            oy = -mag_s;
          end else oy = mag_s;
        end
        OP_HSCROLL: begin
          rwd = rw_s - mag_s;
          if (sh_neg) begin
            rx = px_s + mag_s;
            ox = -mag_s;
          end else ox = mag_s;
        end
        default: ;
      endcase
    end else if (!cmd.prep) begin
      case (op_r)
        OP_VSCROLL: begin
          rht = mag_s;
          if (sh_neg) ry = py_s + rh_s - mag_s;
        end
        OP_HSCROLL: begin
          rwd = mag_s;
          if (sh_neg) rx = px_s + rw_s - mag_s;
        end
        default: ;
      endcase
    end
  end

  // clip to screen
  sval_t x0c, y0c, x1c, y1c, x1t, y1t;
  logic  ne_c;
  always_comb begin
    x0c  = (rx < 0) ? '0 : rx;
    y0c  = (ry < 0) ? '0 : ry;
    x1t  = rx + rwd - sval_t'(1);
    y1t  = ry + rht - sval_t'(1);
    x1c  = (x1t >= ec_s) ? ec_s - sval_t'(1) : x1t;
    y1c  = (y1t >= er_s) ? er_s - sval_t'(1) : y1t;
    ne_c = (x0c <= x1c) && (y0c <= y1c);
  end

  // pass kind
  kind_t kind_c;
  always_comb begin
    kind_c = K_NONE;
    if (!cmd.pass) begin
      case (op_r)
        OP_PUT, OP_CP437, OP_FILL: kind_c = K_FILL;
        OP_COPY:                   kind_c = K_BLIT;
        OP_VSCROLL, OP_HSCROLL:    kind_c = sh_zero ? K_NONE : K_BLIT;
        OP_READ:                   kind_c = K_READ;
        default:                   kind_c = K_NONE;
      endcase
    end else if ((op_r == OP_VSCROLL || op_r == OP_HSCROLL) && !sh_zero) begin
      kind_c = K_FILL;
    end
  end

  // cell walker; descends where the offset is positive so overlap is safe
  logic [CW-1:0] x0_r, x1_r, i_r;
  logic [RW-1:0] y0_r, y1_r, j_r;
  sval_t         ox_r, oy_r;
  logic          dirx_r, diry_r, ne_r, ne0_r, scr_ne_r, any_r;
  logic          i_end, j_end;
  assign i_end = dirx_r ? (i_r == x0_r) : (i_r == x1_r);
  assign j_end = diry_r ? (j_r == y0_r) : (j_r == y1_r);

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      mag_r    <= magv_s[9:0];
      scr_ne_r <= ne_c;
    end
    if (cmd.load) begin
      x0_r   <= x0c[CW-1:0];
      x1_r   <= x1c[CW-1:0];
      y0_r   <= y0c[RW-1:0];
      y1_r   <= y1c[RW-1:0];
      ox_r   <= ox;
      oy_r   <= oy;
      dirx_r <= (ox > 0);
      diry_r <= (oy > 0);
      i_r    <= (ox > 0) ? x1c[CW-1:0] : x0c[CW-1:0];
      j_r    <= (oy > 0) ? y1c[RW-1:0] : y0c[RW-1:0];
      ne_r   <= ne_c;
      if (!cmd.pass) ne0_r <= ne_c;
    end else if (cmd.step) begin
      if (!i_end) begin
        i_r <= dirx_r ? i_r - CW'(1) : i_r + CW'(1);
      end else begin
        i_r <= dirx_r ? x1_r : x0_r;
        j_r <= diry_r ? j_r - RW'(1) : j_r + RW'(1);
      end
    end
  end

  // copy target
  sval_t         tx, ty;
  logic          tgt_ok;
  logic [AW-1:0] src_addr, tgt_addr;
  assign tx       = sval_t'(i_r) + ox_r;
  assign ty       = sval_t'(j_r) + oy_r;
  assign tgt_ok   = (tx >= 0) && (tx < ec_s) && (ty >= 0) && (ty < er_s);
  assign src_addr = AW'(j_r) * AW'(MAX_COLS) + AW'(i_r);
  assign tgt_addr = AW'(ty[RW-1:0]) * AW'(MAX_COLS) + AW'(tx[CW-1:0]);

  logic [AW-1:0] tgt_addr_r, clr_addr_r;
  logic          tgt_ok_r;
  always_ff @(posedge clk) begin
    if (cmd.blit_rd) begin
      tgt_addr_r <= tgt_addr;
      tgt_ok_r   <= tgt_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_cmd) any_r <= 1'b0;
    else if (cmd.blit_wr && tgt_ok_r) any_r <= 1'b1;
  end

  // clearing pass address
  always_ff @(posedge clk) begin
    if (!rst_n) clr_addr_r <= '0;
    else if (cmd.clr_we) clr_addr_r <= clr_addr_r + AW'(1);
  end

  // cell store: one write, one registered read
  logic [31:0]   mem [DEPTH];
  logic [31:0]   rdata_r, wdata;
  logic [AW-1:0] waddr;
  logic          we, re;
  always_comb begin
    we    = 1'b0;
    waddr = src_addr;
    wdata = cell_r;
    if (cmd.clr_we) begin
      we    = 1'b1;
      waddr = clr_addr_r;
      wdata = '0;
    end else if (cmd.fill_we) begin
      we = 1'b1;
    end else if (cmd.blit_wr) begin
      we    = tgt_ok_r;
      waddr = tgt_addr_r;
      wdata = rdata_r;
    end
  end
  assign re = cmd.blit_rd || cmd.rd;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[src_addr];
  end

  // result register
  logic rd_hit;
  logic skip_c;
  assign rd_hit = (op_r == OP_READ) && ne0_r;
  always_comb begin
    case (op_r)
      OP_PUT, OP_CP437, OP_FILL, OP_READ: skip_c = !ne0_r;
      OP_COPY:                            skip_c = !any_r;
      OP_VSCROLL, OP_HSCROLL:             skip_c = !scr_ne_r;
      default:                            skip_c = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      cell_char <= rd_hit ? rdata_r[15:0]  : '0;
      cell_fg   <= rd_hit ? rdata_r[23:16] : '0;
      cell_bg   <= rd_hit ? rdata_r[31:24] : '0;
      skipped   <= skip_c;
    end
  end

  assign sts.kind     = kind_c;
  assign sts.ne       = ne_r;
  assign sts.last     = i_end && j_end;
  assign sts.clr_last = (clr_addr_r == AW'(DEPTH - 1));

endmodule
